FILE: src/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types and constants of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

   localparam int OPCODE_W = 2;
   localparam int PAGE_W   = 12;
   localparam int COUNT_W  = 13;
   localparam int TOTAL_W  = 13;

   // one map word holds the used bits of this many pages
   localparam int WORD_W = 64;
   localparam int BIT_W  = 6;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
   // pages that the page number field can name
   localparam int PAGE_FIELD_LIMIT = 4096;

   localparam logic [OPCODE_W-1:0] OP_LOCK    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REQUEST = 2'd2;

   typedef struct packed {
      logic clear;
      logic load;
      logic walk;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic walk_needed;
      logic walk_done;
   } ctrl_status_type;

endpackage

FILE: src/pfba_if.sv
// ----------------------------------------------------------------------------
// pfba_req_if / pfba_rsp_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface pfba_req_if;
   logic                             valid;
   logic                             ready;
   logic [pfba_pkg::OPCODE_W-1:0]    opcode;
   logic [pfba_pkg::PAGE_W-1:0]      start_page;
   logic [pfba_pkg::COUNT_W-1:0]     run_length;

   modport source (output valid, output opcode, output start_page, output run_length,
                   input ready);
   modport sink (input valid, input opcode, input start_page, input run_length,
                 output ready);
endinterface

interface pfba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pfba_pkg::PAGE_W-1:0]   page_number;
   logic                          success;

   modport source (output valid, output page_number, output success, input ready);
   modport sink (input valid, input page_number, input success, output ready);
endinterface

FILE: src/pfba_ram.sv
// ----------------------------------------------------------------------------
// pfba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfba_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                      wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                      rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pfba_ctrl.sv
// ----------------------------------------------------------------------------
// pfba_ctrl
// Sequencer: clearing pass, accept, map walk and result hand-off.
// ----------------------------------------------------------------------------
module pfba_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  pfba_pkg::ctrl_status_type  status,
   output pfba_pkg::ctrl_cmd_type     cmd
);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_WALK   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = status.walk_needed ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result word held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/pfba_dpath.sv
// ----------------------------------------------------------------------------
// pfba_dpath
// Map storage, word walker, range masks, free-bit search and result registers.
// ----------------------------------------------------------------------------
module pfba_dpath #(
   parameter int MAX_PAGES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pfba_pkg::TOTAL_W-1:0]     csr_wr_data,
   input  logic [pfba_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [pfba_pkg::PAGE_W-1:0]      req_start_page,
   input  logic [pfba_pkg::COUNT_W-1:0]     req_run_length,
   output logic [pfba_pkg::PAGE_W-1:0]      rsp_page_number,
   output logic                             rsp_success,
   input  pfba_pkg::ctrl_cmd_type           cmd,
   output pfba_pkg::ctrl_status_type        status
);

   localparam int WORD_W  = pfba_pkg::WORD_W;
   localparam int BIT_W   = pfba_pkg::BIT_W;
   localparam int DEPTH   = (MAX_PAGES + WORD_W - 1) / WORD_W;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // wide enough for start plus count and for MAX_PAGES itself
   localparam int LIM_W   = ($clog2(MAX_PAGES) + 1 > 14) ? $clog2(MAX_PAGES) + 1 : 14;
   localparam logic [LIM_W-1:0]  MAX_LIM    = LIM_W'(MAX_PAGES);
   localparam logic [LIM_W-1:0]  FIELD_LIM  = LIM_W'(pfba_pkg::PAGE_FIELD_LIMIT);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
   localparam logic [BIT_W-1:0]  TOP_BIT    = BIT_W'(WORD_W - 1);

   // configuration
   logic [pfba_pkg::TOTAL_W-1:0] total_ff;

   // span of the accepted word
   logic                 is_range, is_req;
   logic [LIM_W-1:0]     first_ext, end_ext, end_clip;
   logic [LIM_W-1:0]     lim_a, lim_b;
   logic [LIM_W-1:0]     span_lo, span_hi, last_page;
   logic [LIM_W-BIT_W-1:0] lo_word_full, hi_word_full;

   // latched operation
   logic                 search_ff;
   logic                 used_ff;
   logic [ADDR_W-1:0]    lo_word_ff, hi_word_ff;
   logic [BIT_W-1:0]     lo_bit_ff, hi_bit_ff;

   // walker
   logic                 issue_go;
   logic                 issue_more_ff, issue_more_in;
   logic [ADDR_W-1:0]    issue_ptr_ff, issue_ptr_in;
   logic                 proc_valid_ff;
   logic [ADDR_W-1:0]    proc_ptr_ff;
   logic [ADDR_W-1:0]    clr_ptr_ff;

   // word processing
   logic [WORD_W-1:0]    rd_data;
   logic [WORD_W-1:0]    lo_mask, hi_mask, mask, cand;
   logic [WORD_W-1:0]    new_word;
   logic [BIT_W-1:0]     hit_bit;
   logic                 found;
   logic                 proc_act;
   logic [ADDR_W+BIT_W-1:0] hit_page;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_W-1:0]    wr_data;

   // result
   logic [pfba_pkg::PAGE_W-1:0] res_page_ff;
   logic                        res_ok_ff;
   logic [pfba_pkg::PAGE_W-1:0] rsp_page_ff;
   logic                        rsp_ok_ff;

   assign is_range = (req_opcode == pfba_pkg::OP_LOCK) || (req_opcode == pfba_pkg::OP_FREE);
   assign is_req   = (req_opcode == pfba_pkg::OP_REQUEST);

   assign first_ext = LIM_W'(req_start_page);
   assign end_ext   = first_ext + LIM_W'(req_run_length);
   assign end_clip  = (end_ext > MAX_LIM) ? MAX_LIM : end_ext;
   assign lim_a     = (LIM_W'(total_ff) > MAX_LIM) ? MAX_LIM : LIM_W'(total_ff);
   assign lim_b     = (lim_a > FIELD_LIM) ? FIELD_LIM : lim_a;

   assign span_lo   = is_req ? '0 : first_ext;
   assign span_hi   = is_req ? lim_b : end_clip;
   assign last_page = span_hi - LIM_W'(1);

   assign lo_word_full = span_lo[LIM_W-1:BIT_W];
   assign hi_word_full = last_page[LIM_W-1:BIT_W];

   assign status.walk_needed = (is_range || is_req) && (span_hi > span_lo);
   assign status.clear_last  = (clr_ptr_ff == LAST_ADDR);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         search_ff  <= is_req;
         used_ff    <= (req_opcode == pfba_pkg::OP_LOCK);
         lo_word_ff <= lo_word_full[ADDR_W-1:0];
         hi_word_ff <= hi_word_full[ADDR_W-1:0];
         lo_bit_ff  <= span_lo[BIT_W-1:0];
         hi_bit_ff  <= last_page[BIT_W-1:0];
      end
   end

   // reads run one word ahead of the word being updated
   assign issue_go = cmd.walk && issue_more_ff;

   always_comb begin
      issue_more_in = issue_more_ff;
      issue_ptr_in  = issue_ptr_ff;
      if (cmd.load) begin
         issue_more_in = 1'b1;
         issue_ptr_in  = lo_word_full[ADDR_W-1:0];
      end else if (issue_go) begin
         issue_more_in = (issue_ptr_ff != hi_word_ff);
         issue_ptr_in  = issue_ptr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_more_ff <= 1'b0;
         proc_valid_ff <= 1'b0;
         clr_ptr_ff    <= '0;
         total_ff      <= pfba_pkg::TOTAL_RESET;
      end else begin
         issue_more_ff <= issue_more_in;
         proc_valid_ff <= issue_go;
         if (cmd.clear) begin
            clr_ptr_ff <= clr_ptr_ff + ADDR_W'(1);
         end
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
      end
      issue_ptr_ff <= issue_ptr_in;
      proc_ptr_ff  <= issue_ptr_ff;
   end

   assign lo_mask = (proc_ptr_ff == lo_word_ff) ? ({WORD_W{1'b1}} << lo_bit_ff)
                                                : {WORD_W{1'b1}};
   assign hi_mask = (proc_ptr_ff == hi_word_ff) ? ({WORD_W{1'b1}} >> (TOP_BIT - hi_bit_ff))
                                                : {WORD_W{1'b1}};
   assign mask    = lo_mask & hi_mask;
   assign cand    = ~rd_data & mask;

   // lowest free page in the word
   always_comb begin
      hit_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit_bit = BIT_W'(i);
         end
      end
   end

   assign proc_act = cmd.walk && proc_valid_ff;
   assign found    = search_ff && (cand != '0);
   assign hit_page = {proc_ptr_ff, hit_bit};

   always_comb begin
      if (search_ff) begin
         new_word = rd_data | (WORD_W'(1) << hit_bit);
      end else if (used_ff) begin
         new_word = rd_data | mask;
      end else begin
         new_word = rd_data & ~mask;
      end
   end

   assign status.walk_done = proc_act && (found || (proc_ptr_ff == hi_word_ff));

   assign wr_en   = cmd.clear || (proc_act && (!search_ff || found));
   assign wr_addr = cmd.clear ? clr_ptr_ff : proc_ptr_ff;
   assign wr_data = cmd.clear ? {WORD_W{1'b1}} : new_word;

   pfba_ram #(
      .DATA_W (WORD_W),
      .DEPTH  (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue_go),
      .rd_addr (issue_ptr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_page_ff <= '0;
         res_ok_ff   <= is_range;
      end else if (proc_act && found) begin
         res_page_ff <= pfba_pkg::PAGE_W'(hit_page);
         res_ok_ff   <= 1'b1;
      end
      if (cmd.emit) begin
         rsp_page_ff <= res_page_ff;
         rsp_ok_ff   <= res_ok_ff;
      end
   end

   assign rsp_page_number = rsp_page_ff;
   assign rsp_success     = rsp_ok_ff;

endmodule

FILE: src/page_frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// Page frame allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// The map is kept in a RAM of 64-bit words, one bit per page, and every
// operation walks it one word per cycle with one read port and one write
// port. A lock or free range walks the words it touches; a request scans
// the words up to the first free page, at most ceil(limit / 64) words, so
// 64 with 4096 pages searched. An operation with nothing to walk (zero
// count, unused opcode, total of zero) goes straight to its result.
// One operation is worked on at a time; the next word may be accepted while
// the previous result is still waiting. After reset a clearing pass marks
// every page used, ceil(MAX_PAGES / 64) words, before the first word is
// accepted; total_pages may be written during that pass.
module page_frame_bitmap_allocator_core #(
   parameter int MAX_PAGES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   pfba_req_if.sink                      req_bus,
   pfba_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [pfba_pkg::TOTAL_W-1:0]  csr_wr_data
);

   pfba_pkg::ctrl_cmd_type    cmd;
   pfba_pkg::ctrl_status_type status;

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfba_dpath #(
      .MAX_PAGES (MAX_PAGES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_opcode      (req_bus.opcode),
      .req_start_page  (req_bus.start_page),
      .req_run_length  (req_bus.run_length),
      .rsp_page_number (rsp_bus.page_number),
      .rsp_success     (rsp_bus.success),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page frame bitmap allocator core. A directed
// table covers the reset map, range ends, zero and oversize counts and the
// unused opcode. Random phases follow, each under its own total_pages
// setting. Every accepted operation word is run through a bit-level model
// of the used map, and each result word is compared with the oldest
// expected one.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAP_PAGES      = 4096;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int TAIL_CYCLES    = 200;
   localparam int PHASE_WORDS    = 70;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [pfba_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [pfba_pkg::PAGE_W-1:0] page_number;
      logic                        success;
   } alloc_result_type;

   typedef struct packed {
      logic [pfba_pkg::OPCODE_W-1:0] opcode;
      logic [pfba_pkg::PAGE_W-1:0]   start_page;
      logic [pfba_pkg::COUNT_W-1:0]  run_length;
      logic                          typed;
      alloc_result_type              result;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [pfba_pkg::TOTAL_W-1:0] csr_wr_data;

   pfba_req_if req_bus ();
   pfba_rsp_if rsp_bus ();

   page_frame_bitmap_allocator_core #(
      .MAX_PAGES(MAP_PAGES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // bench copy of the used map and of the total register
   logic                         frame_used [0:MAP_PAGES-1];
   logic [pfba_pkg::TOTAL_W-1:0] total_setting;
   alloc_result_type             expected_results [$];

   int unsigned cycle_count;
   int unsigned fault_count;
   int unsigned stall_left;
   bit          send_gap_on;
   bit          rsp_stall_on;
   bit          hold_off_pending;

   // special words: map all used after reset, unused opcode, zero count,
   // ranges running past the store, full-map free and lock, word edges
   stim_row_type directed_rows [0:21] = '{
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b1, '{12'd0, 1'b0}},
      '{OP_UNUSED,            12'hFFF, 13'h1FFF, 1'b1, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_FREE,    12'h000, 13'h0000, 1'b1, '{12'd0, 1'b1}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b1, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_FREE,    12'hFFF, 13'h1FFF, 1'b1, '{12'd0, 1'b1}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b1, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_FREE,    12'h000, 13'd4096, 1'b1, '{12'd0, 1'b1}},
      '{pfba_pkg::OP_REQUEST, 12'hFFF, 13'h1FFF, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_LOCK,    12'h000, 13'h1FFF, 1'b1, '{12'd0, 1'b1}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b1, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_FREE,    12'hAAA, 13'h0155, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_FREE,    12'h555, 13'h0AAA, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_LOCK,    12'h600, 13'h0100, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_LOCK,    12'h000, 13'h0AAA, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_FREE,    12'd63,  13'd2,    1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b0, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b0, '{12'd0, 1'b0}},
      '{OP_UNUSED,            12'h000, 13'h0000, 1'b1, '{12'd0, 1'b0}},
      '{pfba_pkg::OP_REQUEST, 12'h000, 13'h0000, 1'b0, '{12'd0, 1'b0}}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int unsigned search_bound();
      int unsigned bound;
      bound = total_setting;
      if (bound > MAP_PAGES) bound = MAP_PAGES;
      if (bound > pfba_pkg::PAGE_FIELD_LIMIT) bound = pfba_pkg::PAGE_FIELD_LIMIT;
      return bound;
   endfunction

   // applies one operation word to the bench map and returns its result word
   function automatic alloc_result_type predict_allocation(
         input logic [pfba_pkg::OPCODE_W-1:0] opcode,
         input logic [pfba_pkg::PAGE_W-1:0]   start_page,
         input logic [pfba_pkg::COUNT_W-1:0]  run_length);
      alloc_result_type res;
      int unsigned      first;
      int unsigned      stop;
      int unsigned      bound;
      bit               found;
      res   = '0;
      found = 1'b0;
      first = start_page;
      stop  = first + run_length;
      if (stop > MAP_PAGES) stop = MAP_PAGES;
      case (opcode)
         pfba_pkg::OP_LOCK, pfba_pkg::OP_FREE: begin
            for (int unsigned p = first; p < stop; p++)
               frame_used[p] = (opcode == pfba_pkg::OP_LOCK);
            res.success = 1'b1;
         end
         pfba_pkg::OP_REQUEST: begin
            bound = search_bound();
            for (int unsigned p = 0; p < bound; p++) begin
               if (!found && !frame_used[p]) begin
                  found           = 1'b1;
                  frame_used[p]   = 1'b1;
                  res.page_number = pfba_pkg::PAGE_W'(p);
                  res.success     = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic offer_word(input logic [pfba_pkg::OPCODE_W-1:0] opcode,
                             input logic [pfba_pkg::PAGE_W-1:0] start_page,
                             input logic [pfba_pkg::COUNT_W-1:0] run_length,
                             input logic typed, input alloc_result_type typed_result);
      alloc_result_type predicted;
      int unsigned      idle;
      idle = send_gap_on ? gap_length() : 0;
      repeat (idle) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= opcode;
      req_bus.start_page <= start_page;
      req_bus.run_length <= run_length;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_allocation(opcode, start_page, run_length);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic random_word();
      logic [pfba_pkg::OPCODE_W-1:0] opcode;
      logic [pfba_pkg::PAGE_W-1:0]   start_page;
      logic [pfba_pkg::COUNT_W-1:0]  run_length;
      int unsigned                   roll;
      int unsigned                   bound;
      roll = $urandom_range(0, 99);
      if (roll < 40)      opcode = pfba_pkg::OP_REQUEST;
      else if (roll < 70) opcode = pfba_pkg::OP_FREE;
      else if (roll < 95) opcode = pfba_pkg::OP_LOCK;
      else                opcode = OP_UNUSED;
      // keep half the ranges inside the searched pages so requests succeed
      bound = search_bound();
      if (bound > 0 && $urandom_range(0, 1) == 1)
         start_page = pfba_pkg::PAGE_W'($urandom_range(0, bound - 1));
      else
         start_page = pfba_pkg::PAGE_W'($urandom_range(0, 4095));
      roll = $urandom_range(0, 99);
      if (roll < 85)      run_length = pfba_pkg::COUNT_W'($urandom_range(0, 96));
      else if (roll < 97) run_length = pfba_pkg::COUNT_W'($urandom_range(97, 1024));
      else                run_length = pfba_pkg::COUNT_W'($urandom_range(0, 8191));
      offer_word(opcode, start_page, run_length, 1'b0, '0);
   endtask

   // sender goes quiet until every result word is back
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_total(input logic [pfba_pkg::TOTAL_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en     <= 1'b0;
      total_setting = value;
   endtask

   // result side: ready with random stalls and one long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      stall_left    = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (hold_off_pending) begin
               stall_left       = HOLD_OFF_LEN;
               hold_off_pending = 1'b0;
            end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
               stall_left = gap_length();
            end
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    = stall_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("%0t: result word with none expected: page %0d success %0b",
                        $realtime, rsp_bus.page_number, rsp_bus.success);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.page_number !== want.page_number || rsp_bus.success !== want.success) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: mismatch: page exp %0d got %0d, success exp %0b got %0b",
                           $realtime, want.page_number, rsp_bus.page_number,
                           want.success, rsp_bus.success);
            end
         end
      end
   end

   initial begin
      logic [pfba_pkg::TOTAL_W-1:0] phase_totals [0:9];
      cycle_count        = 0;
      fault_count        = 0;
      send_gap_on        = 1'b1;
      rsp_stall_on       = 1'b1;
      hold_off_pending   = 1'b0;
      total_setting      = pfba_pkg::TOTAL_RESET;
      for (int i = 0; i < MAP_PAGES; i++) frame_used[i] = 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= pfba_pkg::OP_LOCK;
      req_bus.start_page <= '0;
      req_bus.run_length <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      phase_totals = '{13'd64, 13'd0, 13'd1, 13'd4096, 13'd8191, 13'd65, 13'd4095,
                       13'd2000, 13'd4097,
                       pfba_pkg::TOTAL_W'($urandom_range(1, 4096))};
      @(negedge clock);
      while (reset) @(negedge clock);

      foreach (directed_rows[i])
         offer_word(directed_rows[i].opcode, directed_rows[i].start_page,
                    directed_rows[i].run_length, directed_rows[i].typed,
                    directed_rows[i].result);

      for (int phase = 0; phase < 10; phase++) begin
         settle_block();
         write_total(phase_totals[phase]);
         if (phase == 3) begin
            // back-to-back words against a long result stall fill the block
            send_gap_on      = 1'b0;
            rsp_stall_on     = 1'b1;
            hold_off_pending = 1'b1;
         end else begin
            send_gap_on  = ($urandom_range(0, 3) != 0);
            rsp_stall_on = ($urandom_range(0, 3) != 0);
         end
         repeat (PHASE_WORDS) random_word();
      end

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
